// ----- rtl/core/trss_pkg.sv -----
// trss_pkg: shared types and constants of the task ready and sleep scheduler.
// Used by trss_ctrl, trss_dp and task_ready_and_sleep_scheduler. No dependencies.
package trss_pkg;

   // operation codes
   typedef enum logic [2:0] {
      OP_INSERT      = 3'd0,
      OP_SLEEP       = 3'd1,
      OP_WAKEUP      = 3'd2,
      OP_RESORT      = 3'd3,
      OP_TICK        = 3'd4,
      OP_SCHEDULE    = 3'd5,
      OP_SET_CURRENT = 3'd6,
      OP_NONE        = 3'd7
   } op_type;

   // per-task list state
   localparam logic [1:0] TS_IDLE  = 2'd0;
   localparam logic [1:0] TS_RUN   = 2'd1;
   localparam logic [1:0] TS_SLEEP = 2'd2;

   // response status codes
   localparam logic [1:0] RC_OK         = 2'd0;
   localparam logic [1:0] RC_NOT_READY  = 2'd1;
   localparam logic [1:0] RC_NOT_LISTED = 2'd2;

   localparam logic [31:0] NEVER_TICKS = 32'hFFFF_FFFF;
   localparam logic [4:0]  NO_TASK     = 5'd31;

   typedef struct packed {
      op_type      op;
      logic [3:0]  task_id;
      logic        has_task;
      logic [7:0]  priority_req;
      logic [31:0] sleep_ticks;
      logic        in_isr;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] chosen_task;
      logic       chosen_valid;
      logic       switch_needed;
      logic       switch_from_isr;
      logic [4:0] woken_count;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_RUN_DEL,
      S_RUN_FIND,
      S_SLP_SET,
      S_SLP_DEL,
      S_SLP_FIND,
      S_TICK_CHK,
      S_TICK_TAKE,
      S_DONE
   } fsm_type;

   // controller to datapath
   typedef struct packed {
      logic       latch;
      logic       idx_clr;
      logic       idx_inc;
      logic       idx_to_slp_end;
      logic       set_prio;
      logic       load_key;
      logic       run_del;
      logic       run_put;
      logic       set_sleep;
      logic       clr_wake;
      logic       slp_del;
      logic       slp_put;
      logic       tick;
      logic       take_head;
      logic       woken_inc;
      logic       set_cur;
      logic       code_wr;
      logic [1:0] code;
      logic       load_rsp;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type     op;
      logic       t_valid;
      logic [1:0] t_state;
      logic       has_task;
      logic       forever_req;
      logic       run_hit;
      logic       run_end;
      logic       run_before;
      logic       slp_hit;
      logic       slp_end;
      logic       slp_before;
      logic       head_due;
   } dp_stat_type;

endpackage

// ----- rtl/core/trss_ctrl.sv -----
// trss_ctrl: sequencer for the scheduler; walks the lists one entry a cycle.
// Depends on trss_pkg; drives trss_dp through dp_cmd_type.
module trss_ctrl
   import trss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   fsm_type state_ff, state_in;
   logic    rsp_valid_ff, rsp_valid_in;

   // state and output-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.code_wr = 1'b1;
            cmd.code    = RC_OK;
            state_in    = S_DONE;
            case (stat.op)
               OP_INSERT: begin
                  if (!stat.t_valid) cmd.code = RC_NOT_LISTED;
                  else if (stat.t_state == TS_SLEEP) cmd.code = RC_NOT_READY;
                  else if (stat.t_state != TS_IDLE) cmd.code = RC_NOT_LISTED;
                  else begin
                     cmd.set_prio = 1'b1;
                     cmd.idx_clr  = 1'b1;
                     state_in     = S_RUN_FIND;
                  end
               end
               OP_SLEEP: begin
                  if (!stat.t_valid || stat.t_state != TS_RUN) cmd.code = RC_NOT_LISTED;
                  else begin
                     cmd.idx_clr = 1'b1;
                     state_in    = S_RUN_DEL;
                  end
               end
               OP_WAKEUP: begin
                  if (!stat.t_valid || stat.t_state != TS_SLEEP) cmd.code = RC_NOT_LISTED;
                  else begin
                     cmd.load_key = 1'b1;
                     cmd.clr_wake = 1'b1;
                     cmd.idx_clr  = 1'b1;
                     state_in     = S_SLP_DEL;
                  end
               end
               OP_RESORT: begin
                  if (!stat.t_valid) cmd.code = RC_NOT_LISTED;
                  else if (stat.t_state == TS_SLEEP) cmd.code = RC_NOT_READY;
                  else if (stat.t_state != TS_RUN) cmd.code = RC_NOT_LISTED;
                  else begin
                     cmd.idx_clr = 1'b1;
                     state_in    = S_RUN_DEL;
                  end
               end
               OP_TICK: begin
                  cmd.tick    = 1'b1;
                  cmd.idx_clr = 1'b1;
                  state_in    = S_TICK_CHK;
               end
               OP_SCHEDULE: begin
                  if (stat.has_task && !stat.t_valid) cmd.code = RC_NOT_LISTED;
               end
               OP_SET_CURRENT: begin
                  if (!stat.t_valid) cmd.code = RC_NOT_LISTED;
                  else cmd.set_cur = 1'b1;
               end
               default: ;
            endcase
         end
         // find the task in the run list and unlink it
         S_RUN_DEL: begin
            if (stat.run_end) begin
               state_in = S_DONE;
            end else if (stat.run_hit) begin
               cmd.run_del = 1'b1;
               cmd.idx_clr = 1'b1;
               if (stat.op == OP_RESORT) begin
                  cmd.set_prio = 1'b1;
                  state_in     = S_RUN_FIND;
               end else begin
                  state_in = S_SLP_SET;
               end
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         // priority-ordered insert
         S_RUN_FIND: begin
            if (stat.run_end || stat.run_before) begin
               cmd.run_put = 1'b1;
               if (stat.op == OP_TICK) begin
                  cmd.idx_clr = 1'b1;
                  state_in    = S_TICK_CHK;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_SLP_SET: begin
            cmd.set_sleep = 1'b1;
            if (stat.forever_req) cmd.idx_to_slp_end = 1'b1;
            else cmd.idx_clr = 1'b1;
            state_in = S_SLP_FIND;
         end
         // wake-time ordered insert
         S_SLP_FIND: begin
            if (stat.slp_end || stat.slp_before) begin
               cmd.slp_put = 1'b1;
               state_in    = S_DONE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_SLP_DEL: begin
            if (stat.slp_end) begin
               state_in = S_DONE;
            end else if (stat.slp_hit) begin
               cmd.slp_del = 1'b1;
               cmd.idx_clr = 1'b1;
               state_in    = S_RUN_FIND;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         // wake expired sleep-list heads one at a time
         S_TICK_CHK: begin
            if (stat.head_due) begin
               cmd.take_head = 1'b1;
               state_in      = S_TICK_TAKE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_TICK_TAKE: begin
            cmd.load_key  = 1'b1;
            cmd.clr_wake  = 1'b1;
            cmd.slp_del   = 1'b1;
            cmd.woken_inc = 1'b1;
            cmd.idx_clr   = 1'b1;
            state_in      = S_RUN_FIND;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

endmodule

// ----- rtl/core/trss_dp.sv -----
// trss_dp: task records, run and sleep order lists, time base, response register.
// Depends on trss_pkg; commanded by trss_ctrl.
module trss_dp
   import trss_pkg::*;
#(
   parameter int TASKS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   input  req_type     req_data,
   output dp_stat_type stat,
   output rsp_type     rsp_data
);

   localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1;
   localparam int CW = $clog2(TASKS + 1);

   req_type         req_ff;
   logic [IW-1:0]   t_ff;
   logic [CW-1:0]   idx_ff;
   logic [7:0]      key_prio_ff;
   logic [31:0]     key_wake_ff;
   logic [1:0]      code_ff;
   logic [4:0]      woken_ff;
   logic [31:0]     now_ff;
   logic [4:0]      cur_ff;
   logic [CW-1:0]   run_cnt_ff;
   logic [CW-1:0]   slp_cnt_ff;
   logic [1:0]      st_ff    [TASKS];
   logic [7:0]      prio_ff  [TASKS];
   logic [31:0]     wake_ff  [TASKS];
   logic            fe_ff    [TASKS];
   logic [IW-1:0]   run_list_ff [TASKS];
   logic [IW-1:0]   slp_list_ff [TASKS];
   rsp_type         rsp_ff;

   logic [IW-1:0] idx_w;
   logic [IW-1:0] run_e;
   logic [IW-1:0] slp_e;
   logic [IW-1:0] prio_addr;
   logic [7:0]    prio_rd;
   logic [31:0]   wake_rd;
   logic          fe_rd;
   logic [31:0]   slp_d;
   logic [31:0]   due_d;
   logic [31:0]   wake_new;
   logic          run_put_ok;
   logic          slp_put_ok;
   logic          sch_valid;
   logic [3:0]    sch_task;
   logic          sch_sw;

   // list and record reads
   assign idx_w     = idx_ff[IW-1:0];
   assign run_e     = run_list_ff[idx_w];
   assign slp_e     = slp_list_ff[idx_w];
   assign prio_addr = cmd.load_key ? t_ff : run_e;
   assign prio_rd   = prio_ff[prio_addr];
   assign wake_rd   = wake_ff[slp_e];
   assign fe_rd     = fe_ff[slp_e];
   assign slp_d     = wake_rd - key_wake_ff;
   assign due_d     = now_ff - wake_rd;
   assign wake_new  = now_ff + req_ff.sleep_ticks;
   assign run_put_ok = cmd.run_put && (run_cnt_ff < CW'(TASKS));
   assign slp_put_ok = cmd.slp_put && (slp_cnt_ff < CW'(TASKS));

   // status to controller
   always_comb begin
      stat.op          = req_ff.op;
      stat.t_valid     = ({28'd0, req_ff.task_id} < 32'(TASKS));
      stat.t_state     = st_ff[t_ff];
      stat.has_task    = req_ff.has_task;
      stat.forever_req = (req_ff.sleep_ticks == NEVER_TICKS);
      stat.run_hit     = (run_e == t_ff);
      stat.run_end     = (idx_ff == run_cnt_ff);
      stat.run_before  = (key_prio_ff < prio_rd);
      stat.slp_hit     = (slp_e == t_ff);
      stat.slp_end     = (idx_ff == slp_cnt_ff);
      stat.slp_before  = fe_rd || ((slp_d != 32'd0) && !slp_d[31]);
      stat.head_due    = (slp_cnt_ff != '0) && !fe_rd && !due_d[31];
   end

   // request latch, scan index and keys
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff <= req_data;
         t_ff   <= IW'(req_data.task_id);
      end else if (cmd.take_head) begin
         t_ff <= slp_e;
      end
      if (cmd.idx_clr) idx_ff <= '0;
      else if (cmd.idx_inc) idx_ff <= idx_ff + 1'b1;
      else if (cmd.idx_to_slp_end) idx_ff <= slp_cnt_ff;
      if (cmd.set_prio) key_prio_ff <= req_ff.priority_req;
      else if (cmd.load_key) key_prio_ff <= prio_rd;
      if (cmd.set_sleep) key_wake_ff <= wake_new;
      if (cmd.code_wr) code_ff <= cmd.code;
   end

   // control state: counts, time, current task, task records
   always_ff @(posedge clock) begin
      if (reset) begin
         woken_ff   <= '0;
         now_ff     <= '0;
         cur_ff     <= NO_TASK;
         run_cnt_ff <= '0;
         slp_cnt_ff <= '0;
         for (int j = 0; j < TASKS; j++) begin
            st_ff[j]   <= TS_IDLE;
            prio_ff[j] <= '0;
            wake_ff[j] <= '0;
            fe_ff[j]   <= 1'b0;
         end
      end else begin
         if (cmd.latch) woken_ff <= '0;
         else if (cmd.woken_inc) woken_ff <= woken_ff + 5'd1;
         if (cmd.tick) now_ff <= now_ff + 32'd1;
         if (cmd.set_cur) cur_ff <= {1'b0, req_ff.task_id};
         if (cmd.run_del) run_cnt_ff <= run_cnt_ff - 1'b1;
         else if (run_put_ok) run_cnt_ff <= run_cnt_ff + 1'b1;
         if (cmd.slp_del) slp_cnt_ff <= slp_cnt_ff - 1'b1;
         else if (slp_put_ok) slp_cnt_ff <= slp_cnt_ff + 1'b1;
         if (cmd.set_prio) prio_ff[t_ff] <= req_ff.priority_req;
         if (cmd.run_put) st_ff[t_ff] <= TS_RUN;
         else if (cmd.slp_put) st_ff[t_ff] <= TS_SLEEP;
         if (cmd.set_sleep) begin
            wake_ff[t_ff] <= wake_new;
            fe_ff[t_ff]   <= (req_ff.sleep_ticks == NEVER_TICKS);
         end else if (cmd.clr_wake) begin
            wake_ff[t_ff] <= '0;
            fe_ff[t_ff]   <= 1'b0;
         end
      end
   end

   // order lists: shift out on unlink, shift in on insert
   always_ff @(posedge clock) begin
      for (int j = 0; j < TASKS - 1; j++) begin
         if (cmd.run_del && CW'(j) >= idx_ff) run_list_ff[j] <= run_list_ff[j+1];
         if (cmd.slp_del && CW'(j) >= idx_ff) slp_list_ff[j] <= slp_list_ff[j+1];
      end
      for (int j = 1; j < TASKS; j++) begin
         if (run_put_ok && CW'(j) > idx_ff) run_list_ff[j] <= run_list_ff[j-1];
         if (slp_put_ok && CW'(j) > idx_ff) slp_list_ff[j] <= slp_list_ff[j-1];
      end
      if (run_put_ok) run_list_ff[idx_w] <= t_ff;
      if (slp_put_ok) slp_list_ff[idx_w] <= t_ff;
   end

   // schedule pick
   always_comb begin
      sch_valid = 1'b0;
      sch_task  = '0;
      if (req_ff.op == OP_SCHEDULE) begin
         if (req_ff.has_task) begin
            sch_valid = stat.t_valid;
            sch_task  = stat.t_valid ? req_ff.task_id : 4'd0;
         end else if (run_cnt_ff != '0) begin
            sch_valid = 1'b1;
            sch_task  = 4'(run_list_ff[0]);
         end
      end
      sch_sw = sch_valid && ({1'b0, sch_task} != cur_ff);
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.status          <= code_ff;
         rsp_ff.chosen_task     <= sch_task;
         rsp_ff.chosen_valid    <= sch_valid;
         rsp_ff.switch_needed   <= sch_sw;
         rsp_ff.switch_from_isr <= sch_sw && req_ff.in_isr;
         rsp_ff.woken_count     <= woken_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- rtl/core/task_ready_and_sleep_scheduler.sv -----
// task_ready_and_sleep_scheduler: top level, priority run list and timed sleep list.
// Depends on trss_pkg, trss_ctrl and trss_dp.
//
//   channel | ports                          | moves
//   req     | req_valid, req_ready, req_data | one operation request (req_type)
//   rsp     | rsp_valid, rsp_ready, rsp_data | one result per request (rsp_type)
//
// One request at a time. Insert, wakeup, resort and sleep walk the order lists
// one entry a cycle; a tick wakes due sleep-list heads one at a time and walks
// the run list to reinsert each woken task.
// Reset clears all task records, counts, time and current task.
// The result register lets a new request be taken while rsp is stalled; that
// new request waits in the final state until the held result is taken.
module task_ready_and_sleep_scheduler
   import trss_pkg::*;
#(
   parameter int TASKS = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   trss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   trss_dp #(
      .TASKS (TASKS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

   // one request in flight
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   // a run-list insert never comes with a run-list unlink or a sleep-list command
   a_list_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd.run_put |-> !(cmd.run_del || cmd.slp_put || cmd.slp_del))
      else $error("conflicting list commands");

   // a loaded result shows up as valid
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid)
      else $error("result loaded but not valid");

endmodule
